// ----- src/lpm_pkg.sv -----
`timescale 1ns / 1ps
package lpm_pkg;

  // Table sizing
  localparam int PREFIX_DEPTH = 4096;
  localparam int EXACT_DEPTH  = 4096;
  localparam int KEY_BYTES    = 16;

  localparam int KEY_W    = 128;
  localparam int LEN_W    = 5;
  localparam int LAT_W    = 15;
  localparam int LON_W    = 16;
  localparam int PLACE_W  = LAT_W + LON_W;
  localparam int PCNT_W   = $clog2(PREFIX_DEPTH + 1);
  localparam int XCNT_W   = $clog2(EXACT_DEPTH + 1);
  localparam int PIDX_W   = $clog2(PREFIX_DEPTH);
  localparam int XIDX_W   = $clog2(EXACT_DEPTH);
  localparam int SCAN_W   = (PCNT_W > XCNT_W) ? PCNT_W : XCNT_W;

  // Request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_PREFIX = 2'd1;
  localparam logic [1:0] REQ_EXACT  = 2'd2;
  localparam logic [1:0] REQ_LOOKUP = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Table select for a scan
  localparam logic SEL_EXACT  = 1'b0;
  localparam logic SEL_PREFIX = 1'b1;

  typedef struct packed {
    logic [PLACE_W-1:0] place;
    logic [LEN_W-1:0]   size;
    logic [KEY_W-1:0]   key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic       load;
    logic       clr_counts;
    logic       wr_prefix;
    logic       wr_exact_new;
    logic       wr_exact_hit;
    logic       scan_start;
    logic       scan_step;
    logic       scan_sel;
    logic       set_status;
    logic [1:0] status_code;
    logic       post;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req;
    logic       len_zero;
    logic       prefix_full;
    logic       exact_full;
    logic       scan_done;
    logic       x_hit;
    logic       out_free;
  } sts_t;

  // Upper-case letters, zero bytes at or past len
  function automatic logic [KEY_W-1:0] fold_key(input logic [KEY_W-1:0] k,
                                                input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] r;
    logic [7:0] c;
    r = '0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      c = k[8*b +: 8];
      if (LEN_W'(b) >= len) begin
        c = 8'h00;
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        c = c - 8'h20;
      end
      r[8*b +: 8] = c;
    end
    return r;
  endfunction

  // Byte mask covering the first len bytes
  function automatic logic [KEY_W-1:0] key_mask(input logic [LEN_W-1:0] len);
    logic [KEY_W-1:0] r;
    r = '0;
    for (int b = 0; b < KEY_W / 8; b++) begin
      if (LEN_W'(b) < len) begin
        r[8*b +: 8] = 8'hFF;
      end
    end
    return r;
  endfunction

endpackage

// ----- src/lpm_ram.sv -----
`timescale 1ns / 1ps
module lpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/lpm_datapath.sv -----
`timescale 1ns / 1ps
module lpm_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  lpm_pkg::cmd_t               cmd,
  output lpm_pkg::sts_t               sts,
  input  logic [1:0]                  req_type,
  input  logic [63:0]                 key_low,
  input  logic [63:0]                 key_high,
  input  logic [4:0]                  key_length,
  input  logic signed [14:0]          latitude_in,
  input  logic signed [15:0]          longitude_in,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output logic                        found,
  output logic signed [14:0]          latitude,
  output logic signed [15:0]          longitude,
  output logic [1:0]                  status
);

  logic [1:0]                         req;
  logic [lpm_pkg::KEY_W-1:0]          key;
  logic [lpm_pkg::LEN_W-1:0]          len;
  logic [lpm_pkg::PLACE_W-1:0]        place;
  logic [lpm_pkg::PCNT_W-1:0]         prefix_count;
  logic [lpm_pkg::XCNT_W-1:0]         exact_count;
  logic [lpm_pkg::SCAN_W-1:0]         idx;
  logic                               pend;
  logic [lpm_pkg::XIDX_W-1:0]         pend_idx;
  logic                               hit;
  logic [lpm_pkg::XIDX_W-1:0]         hit_idx;
  logic [lpm_pkg::PLACE_W-1:0]        hit_place;
  logic [lpm_pkg::LEN_W-1:0]          best;
  logic [1:0]                         res_status;

  logic [lpm_pkg::LEN_W-1:0]          len_sat;
  logic [lpm_pkg::SCAN_W-1:0]         cur_count;
  logic                               rd_go;
  lpm_pkg::entry_t                    p_rd;
  lpm_pkg::entry_t                    x_rd;
  lpm_pkg::entry_t                    new_entry;
  logic                               x_match;
  logic                               p_match;
  logic                               x_wr;
  logic [lpm_pkg::XIDX_W-1:0]         x_wr_addr;
  logic                               lookup_hit;

  // Saturate the key length
  assign len_sat = (key_length > lpm_pkg::LEN_W'(lpm_pkg::KEY_BYTES)) ?
                   lpm_pkg::LEN_W'(lpm_pkg::KEY_BYTES) : key_length;

  assign cur_count = (cmd.scan_sel == lpm_pkg::SEL_PREFIX) ?
                     lpm_pkg::SCAN_W'(prefix_count) : lpm_pkg::SCAN_W'(exact_count);
  assign rd_go = cmd.scan_step && !cmd.scan_start && (idx < cur_count);

  assign new_entry = '{place: place, size: len, key: key};

  // Entry compares on returned read data
  assign x_match = (x_rd.size == len) && (x_rd.key == key);
  assign p_match = (p_rd.size > best) && (p_rd.size <= len) &&
                   ((key & lpm_pkg::key_mask(p_rd.size)) == p_rd.key);

  assign x_wr      = cmd.wr_exact_new || cmd.wr_exact_hit;
  assign x_wr_addr = cmd.wr_exact_hit ? hit_idx : exact_count[lpm_pkg::XIDX_W-1:0];

  lpm_ram #(.WIDTH(lpm_pkg::ENTRY_W), .DEPTH(lpm_pkg::PREFIX_DEPTH)) u_prefix_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_prefix),
    .wr_addr (prefix_count[lpm_pkg::PIDX_W-1:0]),
    .wr_data (new_entry),
    .rd_en   (rd_go && (cmd.scan_sel == lpm_pkg::SEL_PREFIX)),
    .rd_addr (idx[lpm_pkg::PIDX_W-1:0]),
    .rd_data (p_rd)
  );

  lpm_ram #(.WIDTH(lpm_pkg::ENTRY_W), .DEPTH(lpm_pkg::EXACT_DEPTH)) u_exact_ram (
    .clk     (clk),
    .wr_en   (x_wr),
    .wr_addr (x_wr_addr),
    .wr_data (new_entry),
    .rd_en   (rd_go && (cmd.scan_sel == lpm_pkg::SEL_EXACT)),
    .rd_addr (idx[lpm_pkg::XIDX_W-1:0]),
    .rd_data (x_rd)
  );

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req   <= req_type;
      len   <= len_sat;
      key   <= lpm_pkg::fold_key({key_high, key_low}, len_sat);
      place <= {longitude_in, latitude_in};
    end
  end

  // Table fill counts
  always_ff @(posedge clk) begin
    if (rst || cmd.clr_counts) begin
      prefix_count <= '0;
      exact_count  <= '0;
    end else begin
      if (cmd.wr_prefix) begin
        prefix_count <= prefix_count + 1'b1;
      end
      if (cmd.wr_exact_new) begin
        exact_count <= exact_count + 1'b1;
      end
    end
  end

  // Scan pointer and read pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      idx  <= '0;
      pend <= 1'b0;
    end else if (cmd.scan_start) begin
      idx  <= '0;
      pend <= 1'b0;
    end else if (cmd.scan_step) begin
      pend <= rd_go;
      if (rd_go) begin
        idx <= idx + 1'b1;
      end
    end else begin
      pend <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_go) begin
      pend_idx <= idx[lpm_pkg::XIDX_W-1:0];
    end
  end

  // Match tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (cmd.load || cmd.scan_start) begin
      hit <= 1'b0;
    end else if (cmd.scan_step && pend) begin
      if (cmd.scan_sel == lpm_pkg::SEL_EXACT) begin
        if (x_match && !hit) begin
          hit <= 1'b1;
        end
      end else if (p_match) begin
        hit <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load || cmd.scan_start) begin
      hit_place <= '0;
      best      <= '0;
    end else if (cmd.scan_step && pend) begin
      if (cmd.scan_sel == lpm_pkg::SEL_EXACT) begin
        if (x_match && !hit) begin
          hit_place <= x_rd.place;
          hit_idx   <= pend_idx;
        end
      end else if (p_match) begin
        hit_place <= p_rd.place;
        best      <= p_rd.size;
      end
    end
  end

  // Result status code
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res_status <= lpm_pkg::ST_DONE;
    end else if (cmd.set_status) begin
      res_status <= cmd.status_code;
    end
  end

  assign lookup_hit = hit && (req == lpm_pkg::REQ_LOOKUP);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.post) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.post) begin
      found     <= lookup_hit;
      latitude  <= lookup_hit ? hit_place[lpm_pkg::LAT_W-1:0] : '0;
      longitude <= lookup_hit ? hit_place[lpm_pkg::PLACE_W-1:lpm_pkg::LAT_W] : '0;
      status    <= res_status;
    end
  end

  // Status to controller
  always_comb begin
    sts.req         = req;
    sts.len_zero    = (len == '0);
    sts.prefix_full = (prefix_count >= lpm_pkg::PCNT_W'(lpm_pkg::PREFIX_DEPTH));
    sts.exact_full  = (exact_count >= lpm_pkg::XCNT_W'(lpm_pkg::EXACT_DEPTH));
    sts.scan_done   = (idx >= cur_count) && !pend;
    sts.x_hit       = hit;
    sts.out_free    = !rsp_valid || !rsp_stall;
  end

endmodule

// ----- src/lpm_ctrl.sv -----
`timescale 1ns / 1ps
module lpm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  lpm_pkg::sts_t sts,
  output lpm_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_XSCAN  = 3'd2;
  localparam logic [2:0] S_PSCAN  = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing of one request
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_FINISH;
        unique case (sts.req)
          lpm_pkg::REQ_CLEAR: begin
            cmd.clr_counts = 1'b1;
          end
          lpm_pkg::REQ_PREFIX: begin
            if (sts.len_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = lpm_pkg::ST_EMPTY;
            end else if (sts.prefix_full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = lpm_pkg::ST_FULL;
            end else begin
              cmd.wr_prefix = 1'b1;
            end
          end
          lpm_pkg::REQ_EXACT: begin
            if (sts.len_zero) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = lpm_pkg::ST_EMPTY;
            end else begin
              cmd.scan_start = 1'b1;
              state_next     = S_XSCAN;
            end
          end
          default: begin
            if (!sts.len_zero) begin
              cmd.scan_start = 1'b1;
              state_next     = S_XSCAN;
            end
          end
        endcase
      end
      S_XSCAN: begin
        cmd.scan_step = 1'b1;
        cmd.scan_sel  = lpm_pkg::SEL_EXACT;
        if (sts.x_hit) begin
          cmd.wr_exact_hit = (sts.req == lpm_pkg::REQ_EXACT);
          state_next       = S_FINISH;
        end else if (sts.scan_done) begin
          if (sts.req == lpm_pkg::REQ_EXACT) begin
            if (sts.exact_full) begin
              cmd.set_status  = 1'b1;
              cmd.status_code = lpm_pkg::ST_FULL;
            end else begin
              cmd.wr_exact_new = 1'b1;
            end
            state_next = S_FINISH;
          end else begin
            cmd.scan_start = 1'b1;
            state_next     = S_PSCAN;
          end
        end
      end
      S_PSCAN: begin
        cmd.scan_step = 1'b1;
        cmd.scan_sel  = lpm_pkg::SEL_PREFIX;
        if (sts.scan_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.post   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- src/longest_prefix_match_table_core.sv -----
`timescale 1ns / 1ps
// Callsign-style lookup table with an exact-key table and a prefix table, each
// holding up to 4096 entries in block RAM. One request is handled at a time and
// each gives one result. Clear and prefix insert need no table scan. An exact insert
// and a lookup scan the exact table one entry per cycle, stopping early on a hit;
// a lookup that misses then scans the prefix table the same way. The scan rate is
// set by the single read port of each table RAM. A new request is taken while the
// previous result still waits on the output.
// No clearing pass after reset: fill counts track the valid entries.
module longest_prefix_match_table_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  logic [1:0]         req_type,
  input  logic [63:0]        key_low,
  input  logic [63:0]        key_high,
  input  logic [4:0]         key_length,
  input  logic signed [14:0] latitude_in,
  input  logic signed [15:0] longitude_in,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output logic               found,
  output logic signed [14:0] latitude,
  output logic signed [15:0] longitude,
  output logic [1:0]         status
);

  lpm_pkg::cmd_t cmd;
  lpm_pkg::sts_t sts;

  lpm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .req_type     (req_type),
    .key_low      (key_low),
    .key_high     (key_high),
    .key_length   (key_length),
    .latitude_in  (latitude_in),
    .longitude_in (longitude_in),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .found        (found),
    .latitude     (latitude),
    .longitude    (longitude),
    .status       (status)
  );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;

  typedef struct {
    logic [1:0]         req;
    logic [63:0]        klo;
    logic [63:0]        khi;
    logic [4:0]         klen;
    logic signed [14:0] lat;
    logic signed [15:0] lon;
  } request_t;

  typedef struct {
    logic               hit;
    logic signed [14:0] lat;
    logic signed [15:0] lon;
    logic [1:0]         st;
  } answer_t;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int SMALL_DEPTH = 64;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [1:0] req_type = lpm_pkg::REQ_CLEAR;
  logic [63:0] key_low = '0;
  logic [63:0] key_high = '0;
  logic [4:0] key_length = '0;
  logic signed [14:0] latitude_in = '0;
  logic signed [15:0] longitude_in = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic found;
  logic signed [14:0] latitude;
  logic signed [15:0] longitude;
  logic [1:0] status;

  longest_prefix_match_table_core uut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .req_type(req_type), .key_low(key_low), .key_high(key_high),
    .key_length(key_length), .latitude_in(latitude_in), .longitude_in(longitude_in),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .found(found), .latitude(latitude), .longitude(longitude), .status(status)
  );

  always #10 clk = ~clk;

  // Shadow copy of both tables
  logic [127:0] pfx_key [lpm_pkg::PREFIX_DEPTH];
  logic [4:0]   pfx_len [lpm_pkg::PREFIX_DEPTH];
  logic [30:0]  pfx_place [lpm_pkg::PREFIX_DEPTH];
  int           pfx_fill = 0;
  logic [127:0] ext_key [lpm_pkg::EXACT_DEPTH];
  logic [4:0]   ext_len [lpm_pkg::EXACT_DEPTH];
  logic [30:0]  ext_place [lpm_pkg::EXACT_DEPTH];
  int           ext_fill = 0;

  request_t pending_reqs[$];
  answer_t  expected_answers[$];
  int errors = 0;
  int sent = 0;
  int answers_seen = 0;
  int hits_seen = 0;
  int send_idle_pct = 34;
  int recv_idle_pct = 46;
  int hold_off = 0;
  int cycles = 0;
  logic req_taken = 1'b0;

  function automatic logic [127:0] folded(logic [127:0] k, int n);
    logic [127:0] r;
    logic [7:0] c;
    r = '0;
    for (int b = 0; b < 16; b++) begin
      c = k[8*b +: 8];
      if (b >= n) c = 8'h00;
      else if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
      r[8*b +: 8] = c;
    end
    return r;
  endfunction

  // Apply one request to the shadow tables and return the expected answer
  function automatic answer_t table_answer(request_t r);
    answer_t a;
    int n;
    int best;
    logic [127:0] k;
    logic [127:0] m;
    logic [30:0] pl;
    bit done;
    a = '{1'b0, '0, '0, lpm_pkg::ST_DONE};
    n = (r.klen > 16) ? 16 : r.klen;
    k = folded({r.khi, r.klo}, n);
    pl = {r.lon, r.lat};
    done = 0;
    case (r.req)
      lpm_pkg::REQ_CLEAR: begin
        pfx_fill = 0;
        ext_fill = 0;
      end
      lpm_pkg::REQ_PREFIX: begin
        if (n == 0) a.st = lpm_pkg::ST_EMPTY;
        else if (pfx_fill >= lpm_pkg::PREFIX_DEPTH) a.st = lpm_pkg::ST_FULL;
        else begin
          pfx_key[pfx_fill] = k; pfx_len[pfx_fill] = 5'(n); pfx_place[pfx_fill] = pl;
          pfx_fill++;
        end
      end
      lpm_pkg::REQ_EXACT: begin
        if (n == 0) a.st = lpm_pkg::ST_EMPTY;
        else begin
          for (int i = 0; i < ext_fill && !done; i++) begin
            if (ext_len[i] == n && ext_key[i] == k) begin
              ext_place[i] = pl;
              done = 1;
            end
          end
          if (!done) begin
            if (ext_fill >= lpm_pkg::EXACT_DEPTH) a.st = lpm_pkg::ST_FULL;
            else begin
              ext_key[ext_fill] = k; ext_len[ext_fill] = 5'(n); ext_place[ext_fill] = pl;
              ext_fill++;
            end
          end
        end
      end
      default: begin
        if (n != 0) begin
          for (int i = 0; i < ext_fill && !done; i++) begin
            if (ext_len[i] == n && ext_key[i] == k) begin
              a.hit = 1; pl = ext_place[i]; done = 1;
            end
          end
          if (!done) begin
            best = 0;
            for (int i = 0; i < pfx_fill; i++) begin
              m = '0;
              for (int b = 0; b < 16; b++) if (b < pfx_len[i]) m[8*b +: 8] = 8'hFF;
              if (pfx_len[i] > best && pfx_len[i] <= n && (k & m) == pfx_key[i]) begin
                best = pfx_len[i]; a.hit = 1; pl = pfx_place[i];
              end
            end
          end
          if (a.hit) begin
            a.lat = pl[14:0];
            a.lon = pl[30:15];
          end
        end
      end
    endcase
    return a;
  endfunction

  // Accepted-transaction tracking for the driver
  always @(posedge clk) begin
    req_taken <= req_valid && !req_stall && !rst;
    if (req_valid && !req_stall && !rst) sent <= sent + 1;
  end

  // Driver: present queued requests at the falling edge
  always @(negedge clk) begin
    if (!rst && (!req_valid || req_taken)) begin
      if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        request_t r;
        r = pending_reqs.pop_front();
        req_valid <= 1'b1;
        req_type <= r.req; key_low <= r.klo; key_high <= r.khi;
        key_length <= r.klen; latitude_in <= r.lat; longitude_in <= r.lon;
        expected_answers = {expected_answers, table_answer(r)};
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Receiver stall, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      rsp_stall <= 1'b1;
      hold_off <= hold_off - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      answer_t e;
      if (expected_answers.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        e = expected_answers.pop_front();
        answers_seen++;
        if (found) hits_seen++;
        if (found !== e.hit) begin
          $error("found: expected %0d, got %0d", e.hit, found); errors++;
        end
        if (latitude !== e.lat) begin
          $error("latitude: expected %0d, got %0d", e.lat, latitude); errors++;
        end
        if (longitude !== e.lon) begin
          $error("longitude: expected %0d, got %0d", e.lon, longitude); errors++;
        end
        if (status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, status); errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Keys drawn from a small letter alphabet so that prefixes collide
  function automatic request_t make_req(logic [1:0] t, int n);
    request_t r;
    logic [7:0] c;
    logic [127:0] k;
    k = {rand64(), rand64()};
    for (int b = 0; b < 16; b++) begin
      if (b < n) begin
        case ($urandom_range(5))
          0: c = 8'h41;
          1: c = 8'h61;
          2: c = 8'h42;
          3: c = 8'h62;
          4: c = 8'h30 + 8'($urandom_range(1));
          default: c = 8'($urandom_range(255));
        endcase
        k[8*b +: 8] = c;
      end
    end
    r.req = t; r.klo = k[63:0]; r.khi = k[127:64];
    r.klen = 5'(n);
    r.lat = 15'($urandom()); r.lon = 16'($urandom());
    return r;
  endfunction

  task automatic push(request_t r);
    pending_reqs = {pending_reqs, r};
  endtask

  task automatic drain();
    while (pending_reqs.size() > 0 || expected_answers.size() > 0) @(posedge clk);
  endtask

  initial begin
    request_t r;
    request_t kept[$];
    int t;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed part: empty keys, long keys, case folding, overwrite, lookups
    push(make_req(lpm_pkg::REQ_LOOKUP, 3));
    push(make_req(lpm_pkg::REQ_PREFIX, 0));
    push(make_req(lpm_pkg::REQ_EXACT, 0));
    r = make_req(lpm_pkg::REQ_PREFIX, 1); r.klo[7:0] = 8'h6B; push(r);
    r.klen = 2; r.klo[15:8] = 8'h31; r.lat = 15'sh3FFF; push(r);
    r.lat = -15'sd16384; r.lon = 16'sh7FFF; push(r);
    r = make_req(lpm_pkg::REQ_PREFIX, 31); r.klo = '1; r.khi = '1; r.lon = -16'sd32768;
    push(r);
    r.req = lpm_pkg::REQ_LOOKUP; push(r);
    r = make_req(lpm_pkg::REQ_EXACT, 4); r.klo = 64'hFFFF_FFFF_6162_7A7B; r.lat = 9000;
    push(r);
    r.lat = -9000; r.lon = 18000; push(r);
    r.klo[31:0] = 32'h4142_5A7B; r.req = lpm_pkg::REQ_LOOKUP; push(r);
    r.klen = 5; push(r);
    r.klen = 3; push(r);
    r = make_req(lpm_pkg::REQ_LOOKUP, 0); push(r);
    r = make_req(lpm_pkg::REQ_LOOKUP, 16); r.klo[15:0] = 16'h316B; push(r);
    r = make_req(lpm_pkg::REQ_EXACT, 16); r.klo = 64'h0; r.khi = 64'h0; push(r);
    r.req = lpm_pkg::REQ_LOOKUP; push(r);
    push(make_req(lpm_pkg::REQ_CLEAR, $urandom_range(16)));
    r.req = lpm_pkg::REQ_LOOKUP; push(r);
    drain();

    // Long hold-off on the receiver while requests keep coming
    for (int i = 0; i < 6; i++) push(make_req(lpm_pkg::REQ_PREFIX, $urandom_range(1, 4)));
    hold_off = 200;
    drain();

    // Random part in three idling phases, tables kept small
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 34 : (ph == 1) ? 46 : 0;
      recv_idle_pct = (ph == 0) ? 46 : (ph == 1) ? 34 : 0;
      for (int i = 0; i < 38; i++) begin
        t = $urandom_range(99);
        if (t < 2) begin
          push(make_req(lpm_pkg::REQ_CLEAR, $urandom_range(31)));
          kept.delete();
        end else if (t < 30) begin
          r = make_req(lpm_pkg::REQ_PREFIX, $urandom_range(0, 6));
          push(r); kept = {kept, r};
        end else if (t < 50) begin
          if (kept.size() > 0 && $urandom_range(1)) begin
            r = kept[$urandom_range(kept.size() - 1)]; r.req = lpm_pkg::REQ_EXACT;
            r.lat = 15'($urandom()); r.lon = 16'($urandom());
          end else r = make_req(lpm_pkg::REQ_EXACT, $urandom_range(0, 31));
          push(r); kept = {kept, r};
        end else begin
          if (kept.size() > 0 && $urandom_range(3) != 0) begin
            r = kept[$urandom_range(kept.size() - 1)]; r.req = lpm_pkg::REQ_LOOKUP;
            if ($urandom_range(1)) begin
              r.klen = 5'($urandom_range(r.klen, 16));
              r.khi = r.khi ^ (rand64() & ~64'hFF);
            end
          end else r = make_req(lpm_pkg::REQ_LOOKUP, $urandom_range(0, 31));
          push(r);
        end
        if (kept.size() > SMALL_DEPTH) kept.delete(0);
      end
      drain();
    end

    repeat (50) @(posedge clk);
    $display("covered %0d requests, %0d results, %0d lookup hits, with a long receiver stall",
             sent, answers_seen, hits_seen);
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// ----- longest_prefix_match_table_core.f -----
src/lpm_pkg.sv
src/lpm_ram.sv
src/lpm_datapath.sv
src/lpm_ctrl.sv
src/longest_prefix_match_table_core.sv
verif/testbench.sv
